// File: rtl/scbp_pkg.sv
package scbp_pkg;

	// Field widths fixed by the stream format.
	localparam int REQ_W     = 24;
	localparam int RID_W     = 8;
	localparam int CLS_W     = 5;
	localparam int ID_OUT_W  = 8;
	localparam int CNT_OUT_W = 9;
	localparam int BYTE_W    = 32;
	localparam int STATUS_W  = 3;

	// Defaults for the top-level parameters.
	localparam int MAX_BUFFERS_DEF  = 256;
	localparam int SIZE_CLASSES_DEF = 24;

	// Configuration register indexes.
	localparam logic REG_MIN_REQ = 1'b0;
	localparam logic REG_MAX_REQ = 1'b1;

	// Operation codes.
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_REUSED    = 3'd0,
		STAT_CREATED   = 3'd1,
		STAT_EXHAUSTED = 3'd2,
		STAT_BAD_SIZE  = 3'd3,
		STAT_BAD_ID    = 3'd4
	} status_t;

	// A classified request as it travels from the front to the back.
	typedef struct packed {
		logic             op;
		logic             kind;
		logic             size_err;
		logic [CLS_W-1:0] cls;
		logic [REQ_W-1:0] req;
		logic [RID_W-1:0] rid;
	} cmd_t;

	// One result item.
	typedef struct packed {
		status_t              status;
		logic [ID_OUT_W-1:0]  granted_id;
		logic [REQ_W-1:0]     granted_bytes;
		logic [CNT_OUT_W-1:0] in_use_count;
		logic [CNT_OUT_W-1:0] created_count;
		logic [BYTE_W-1:0]    total_bytes;
		logic [BYTE_W-1:0]    wasted_bytes;
	} res_t;

	// Rounds a size up to a power of two and returns its log2.
	function automatic logic [CLS_W-1:0] ceil_log2(input logic [REQ_W-1:0] v);
		logic [REQ_W-1:0] m;
		logic [CLS_W-1:0] r;
		m = v - REQ_W'(1);
		r = '0;
		for (int i = 0; i < REQ_W; i++) begin
			if (m[i]) begin
				r = CLS_W'(i + 1);
			end
		end
		if (v == '0) begin
			r = '0;
		end
		return r;
	endfunction

endpackage

// File: rtl/size_class_buffer_pool.sv
// Channel  Direction  Signals                       Contents
// s_*      in         s_tvalid s_tready s_tdata      request item (opcode, kind in tuser)
//                     s_tuser
// m_*      out        m_tvalid m_tready m_tdata      result item (status in tuser)
//                     m_tuser
// cfg_*    in         cfg_we cfg_index cfg_data      size limit registers, write only
//
// A request passes ST_IDLE and ST_LOOK in the back end when it creates a buffer or is
// rejected, and also ST_LINK or ST_RHEAD when it pops or pushes a free list; the first
// memory read (list head or class word of a release) precedes the link or head read.
// Requests are worked one at a time.
// The front takes requests into a two-entry queue while the back end is busy or the
// result register waits for m_tready. Reset clears all lists, counters and the queue
// at once; no clearing pass is needed.
module size_class_buffer_pool #(
	parameter int MAX_BUFFERS  = scbp_pkg::MAX_BUFFERS_DEF,
	parameter int SIZE_CLASSES = scbp_pkg::SIZE_CLASSES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// request_bytes [23:0], release_id [31:24]
	input  logic [31:0]  s_tdata,
	// opcode [0], buffer_kind [1]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// granted_id [7:0], granted_bytes [31:8], in_use_count [40:32],
	// created_count [49:41], total_bytes [81:50], wasted_bytes [113:82], zero [119:114]
	output logic [119:0] m_tdata,
	// status [2:0]
	output logic [2:0]   m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [23:0]  cfg_data
);

	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	scbp_pkg::cmd_t q_wdata;
	scbp_pkg::cmd_t q_rdata;
	scbp_pkg::res_t res;

	scbp_front #(
		.SIZE_CLASSES(SIZE_CLASSES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.opcode       (s_tuser[0]),
		.buffer_kind  (s_tuser[1]),
		.request_bytes(s_tdata[23:0]),
		.release_id   (s_tdata[31:24]),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	scbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(q_wdata),
		.pop    (q_pop),
		.rd_data(q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	scbp_back #(
		.MAX_BUFFERS (MAX_BUFFERS),
		.SIZE_CLASSES(SIZE_CLASSES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	// Result packing, first field in the lowest bits.
	assign m_tuser = res.status;
	assign m_tdata = {6'd0, res.wasted_bytes, res.total_bytes, res.created_count,
		res.in_use_count, res.granted_bytes, res.granted_id};

endmodule

// File: rtl/scbp_front.sv
module scbp_front #(
	parameter int SIZE_CLASSES = scbp_pkg::SIZE_CLASSES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [scbp_pkg::REQ_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic                       buffer_kind,
	input  logic [scbp_pkg::REQ_W-1:0] request_bytes,
	input  logic [scbp_pkg::RID_W-1:0] release_id,
	input  logic                       q_full,
	output logic                       q_push,
	output scbp_pkg::cmd_t             q_data
);

	logic [scbp_pkg::REQ_W-1:0] min_req_q;
	logic [scbp_pkg::REQ_W-1:0] max_req_q;
	logic [scbp_pkg::CLS_W-1:0] cls;
	logic                       cls_big;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_req_q <= scbp_pkg::REQ_W'(1);
			max_req_q <= scbp_pkg::REQ_W'(8388608);
		end else if (cfg_we) begin
			case (cfg_index)
				scbp_pkg::REG_MIN_REQ: min_req_q <= cfg_data;
				scbp_pkg::REG_MAX_REQ: max_req_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Size class and range check for the incoming request.
	assign cls     = scbp_pkg::ceil_log2(request_bytes);
	assign cls_big = {1'b0, cls} >= (scbp_pkg::CLS_W + 1)'(SIZE_CLASSES);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.op       = opcode;
		q_data.kind     = buffer_kind;
		q_data.cls      = cls;
		q_data.req      = request_bytes;
		q_data.rid      = release_id;
		q_data.size_err = (request_bytes == '0) || (request_bytes < min_req_q)
			|| (request_bytes > max_req_q) || cls_big;
	end

endmodule

// File: rtl/scbp_queue.sv
module scbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scbp_pkg::cmd_t wr_data,
	input  logic           pop,
	output scbp_pkg::cmd_t rd_data,
	output logic           full,
	output logic           empty
);

	scbp_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	// Entry storage; a write lands at the write pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_data = slot_q[rd_ptr_q];
	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;

endmodule

// File: rtl/scbp_back.sv
module scbp_back #(
	parameter int MAX_BUFFERS  = scbp_pkg::MAX_BUFFERS_DEF,
	parameter int SIZE_CLASSES = scbp_pkg::SIZE_CLASSES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  scbp_pkg::cmd_t q_data,
	output logic           q_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output scbp_pkg::res_t res
);

	localparam int ID_W   = $clog2(MAX_BUFFERS);
	localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
	localparam int CMP_W  = (CNT_W > scbp_pkg::CNT_OUT_W) ? CNT_W : scbp_pkg::CNT_OUT_W;
	localparam int IDX_W  = (ID_W > scbp_pkg::RID_W) ? ID_W : scbp_pkg::RID_W;
	localparam int LISTS  = 2 * SIZE_CLASSES;
	localparam int LIST_W = $clog2(LISTS);
	localparam int CW_W   = scbp_pkg::CLS_W + 2;
	localparam int B_W    = scbp_pkg::BYTE_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOOK  = 4'b0010,
		ST_LINK  = 4'b0100,
		ST_RHEAD = 4'b1000
	} state_t;

	// Class word: in-use flag, kind, size class.
	logic [ID_W-1:0] head_mem  [LISTS];
	logic [ID_W:0]   link_mem  [MAX_BUFFERS];
	logic [CW_W-1:0] class_mem [MAX_BUFFERS];

	state_t            state_q;
	state_t            state_d;
	scbp_pkg::cmd_t    cmd_q;
	logic [ID_W-1:0]   head_rd_q;
	logic [ID_W:0]     link_rd_q;
	logic [CW_W-1:0]   class_rd_q;
	logic [ID_W-1:0]   id_q;
	logic [LIST_W-1:0] list_q;
	logic [LISTS-1:0]  head_ok_q;
	logic [CNT_W-1:0]  created_q;
	logic [CNT_W-1:0]  in_use_q;
	logic [B_W-1:0]    total_q;
	logic [B_W-1:0]    wasted_q;
	logic              res_valid_q;
	scbp_pkg::res_t    res_q;

	logic              start;
	logic              head_we;
	logic [LIST_W-1:0] head_waddr;
	logic [ID_W-1:0]   head_wdata;
	logic              head_re;
	logic [LIST_W-1:0] head_raddr;
	logic              link_we;
	logic [ID_W-1:0]   link_waddr;
	logic [ID_W:0]     link_wdata;
	logic              link_re;
	logic [ID_W-1:0]   link_raddr;
	logic              class_we;
	logic [ID_W-1:0]   class_waddr;
	logic [CW_W-1:0]   class_wdata;
	logic              head_ok_we;
	logic              head_ok_val;
	logic              id_load;
	logic              list_load;
	logic [LIST_W-1:0] list_d;

	logic [CNT_W-1:0]  created_d;
	logic [CNT_W-1:0]  in_use_d;
	logic [B_W-1:0]    total_d;
	logic [B_W-1:0]    wasted_d;

	logic              fin;
	logic [scbp_pkg::STATUS_W-1:0] fin_status;
	logic [ID_W-1:0]   fin_id;
	logic [B_W-1:0]    fin_bytes;

	logic [IDX_W-1:0]  q_rid_ext;
	logic [IDX_W-1:0]  rid_ext;
	logic [ID_W-1:0]   rid_idx;
	logic [CMP_W-1:0]  rid_big;
	logic [CMP_W-1:0]  created_big;
	logic [CMP_W-1:0]  max_big;
	logic              rid_bad;
	logic [LIST_W-1:0] alloc_list;
	logic [LIST_W-1:0] rel_list;
	logic [B_W-1:0]    alloc_bytes;
	logic [B_W-1:0]    rel_bytes;
	logic [CMP_W-1:0]  in_use_big;
	logic [CMP_W-1:0]  created_out_big;
	logic [IDX_W-1:0]  fin_id_big;

	// Free-list index from buffer kind and size class.
	function automatic logic [LIST_W-1:0] list_of(input logic kind,
		input logic [scbp_pkg::CLS_W-1:0] cls);
		logic [LIST_W-1:0] base;
		base = kind ? LIST_W'(SIZE_CLASSES) : '0;
		return base + LIST_W'(cls);
	endfunction

	assign start = (state_q == ST_IDLE) && !q_empty && (!res_valid_q || res_ready);
	assign q_pop = start;

	assign q_rid_ext   = IDX_W'(q_data.rid);
	assign rid_ext     = IDX_W'(cmd_q.rid);
	assign rid_idx     = rid_ext[ID_W-1:0];
	assign rid_big     = CMP_W'(cmd_q.rid);
	assign created_big = CMP_W'(created_q);
	assign max_big     = CMP_W'(MAX_BUFFERS);
	assign rid_bad     = (rid_big >= created_big) || (rid_big >= max_big)
		|| !class_rd_q[CW_W-1];
	assign alloc_list  = list_of(q_data.kind, q_data.cls);
	assign rel_list    = list_of(class_rd_q[scbp_pkg::CLS_W],
		class_rd_q[scbp_pkg::CLS_W-1:0]);
	assign alloc_bytes = B_W'(1) << cmd_q.cls;
	assign rel_bytes   = B_W'(1) << class_rd_q[scbp_pkg::CLS_W-1:0];

	// Sequencer: memory accesses, counter updates and the finished result.
	always_comb begin
		state_d     = state_q;
		head_we     = 1'b0;
		head_waddr  = list_q;
		head_wdata  = rid_idx;
		head_re     = 1'b0;
		head_raddr  = alloc_list;
		link_we     = 1'b0;
		link_waddr  = rid_idx;
		link_wdata  = {head_ok_q[list_q], head_rd_q};
		link_re     = 1'b0;
		link_raddr  = head_rd_q;
		class_we    = 1'b0;
		class_waddr = rid_idx;
		class_wdata = {1'b0, class_rd_q[CW_W-2:0]};
		head_ok_we  = 1'b0;
		head_ok_val = 1'b0;
		id_load     = 1'b0;
		list_load   = 1'b0;
		list_d      = alloc_list;
		created_d   = created_q;
		in_use_d    = in_use_q;
		total_d     = total_q;
		wasted_d    = wasted_q;
		fin         = 1'b0;
		fin_status  = scbp_pkg::STAT_BAD_SIZE;
		fin_id      = '0;
		fin_bytes   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					head_re   = q_data.op == scbp_pkg::OP_ALLOC;
					head_raddr = alloc_list;
					list_load = 1'b1;
					list_d    = alloc_list;
					state_d   = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (cmd_q.op == scbp_pkg::OP_ALLOC) begin
					if (cmd_q.size_err) begin
						fin        = 1'b1;
						fin_status = scbp_pkg::STAT_BAD_SIZE;
						state_d    = ST_IDLE;
					end else if (head_ok_q[list_q]) begin
						link_re    = 1'b1;
						link_raddr = head_rd_q;
						id_load    = 1'b1;
						state_d    = ST_LINK;
					end else if (created_big == max_big) begin
						fin        = 1'b1;
						fin_status = scbp_pkg::STAT_EXHAUSTED;
						state_d    = ST_IDLE;
					end else begin
						class_we    = 1'b1;
						class_waddr = created_q[ID_W-1:0];
						class_wdata = {1'b1, cmd_q.kind, cmd_q.cls};
						link_we     = 1'b1;
						link_waddr  = created_q[ID_W-1:0];
						link_wdata  = '0;
						created_d   = created_q + CNT_W'(1);
						in_use_d    = in_use_q + CNT_W'(1);
						total_d     = total_q + alloc_bytes;
						wasted_d    = wasted_q + alloc_bytes - B_W'(cmd_q.req);
						fin         = 1'b1;
						fin_status  = scbp_pkg::STAT_CREATED;
						fin_id      = created_q[ID_W-1:0];
						fin_bytes   = alloc_bytes;
						state_d     = ST_IDLE;
					end
				end else begin
					if (rid_bad) begin
						fin        = 1'b1;
						fin_status = scbp_pkg::STAT_BAD_ID;
						state_d    = ST_IDLE;
					end else begin
						head_re    = 1'b1;
						head_raddr = rel_list;
						list_load  = 1'b1;
						list_d     = rel_list;
						state_d    = ST_RHEAD;
					end
				end
			end
			ST_LINK: begin
				head_we     = 1'b1;
				head_waddr  = list_q;
				head_wdata  = link_rd_q[ID_W-1:0];
				head_ok_we  = 1'b1;
				head_ok_val = link_rd_q[ID_W];
				class_we    = 1'b1;
				class_waddr = id_q;
				class_wdata = {1'b1, cmd_q.kind, cmd_q.cls};
				in_use_d    = in_use_q + CNT_W'(1);
				fin         = 1'b1;
				fin_status  = scbp_pkg::STAT_REUSED;
				fin_id      = id_q;
				fin_bytes   = alloc_bytes;
				state_d     = ST_IDLE;
			end
			ST_RHEAD: begin
				link_we     = 1'b1;
				link_waddr  = rid_idx;
				link_wdata  = {head_ok_q[list_q], head_rd_q};
				head_we     = 1'b1;
				head_waddr  = list_q;
				head_wdata  = rid_idx;
				head_ok_we  = 1'b1;
				head_ok_val = 1'b1;
				class_we    = 1'b1;
				class_waddr = rid_idx;
				class_wdata = {1'b0, class_rd_q[CW_W-2:0]};
				in_use_d    = in_use_q - CNT_W'(1);
				fin         = 1'b1;
				fin_status  = scbp_pkg::STAT_REUSED;
				fin_id      = rid_idx;
				fin_bytes   = rel_bytes;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memories with registered read data.
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		if (head_re) begin
			head_rd_q <= head_mem[head_raddr];
		end
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (link_re) begin
			link_rd_q <= link_mem[link_raddr];
		end
		if (class_we) begin
			class_mem[class_waddr] <= class_wdata;
		end
		if (start) begin
			class_rd_q <= class_mem[q_rid_ext[ID_W-1:0]];
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= q_data;
		end
		if (id_load) begin
			id_q <= head_rd_q;
		end
		if (list_load) begin
			list_q <= list_d;
		end
	end

	// Result fields sized to the stream format.
	assign in_use_big      = CMP_W'(in_use_d);
	assign created_out_big = CMP_W'(created_d);
	assign fin_id_big      = IDX_W'(fin_id);

	// Control state, counters, list-valid flags and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_ok_q   <= '0;
			created_q   <= '0;
			in_use_q    <= '0;
			total_q     <= '0;
			wasted_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			created_q <= created_d;
			in_use_q  <= in_use_d;
			total_q   <= total_d;
			wasted_q  <= wasted_d;
			if (head_ok_we) begin
				head_ok_q[list_q] <= head_ok_val;
			end
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q.status        <= scbp_pkg::status_t'(fin_status);
			res_q.granted_id    <= fin_id_big[scbp_pkg::ID_OUT_W-1:0];
			res_q.granted_bytes <= fin_bytes[scbp_pkg::REQ_W-1:0];
			res_q.in_use_count  <= in_use_big[scbp_pkg::CNT_OUT_W-1:0];
			res_q.created_count <= created_out_big[scbp_pkg::CNT_OUT_W-1:0];
			res_q.total_bytes   <= total_d;
			res_q.wasted_bytes  <= wasted_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
